// ----- rtl/core/rtp_pkg.sv -----
// shared types and constants for the row to page pixel transposer
`timescale 1ns / 1ps

package rtp_pkg;

    localparam int DEF_MAX_ROW_BYTES = 16;
    localparam int DEF_MAX_PAGES     = 8;

    localparam int ROW_BYTES_W  = 5;
    localparam int PAGE_COUNT_W = 4;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT = 1'b1;

    localparam logic [ROW_BYTES_W-1:0]  ROW_BYTES_RST  = 5'd16;
    localparam logic [PAGE_COUNT_W-1:0] PAGE_COUNT_RST = 4'd8;

    localparam logic [7:0] CMD_COL_RANGE  = 8'h21;
    localparam logic [7:0] CMD_PAGE_RANGE = 8'h22;

    // seven stored rows of one column byte
    localparam int BAND_W = 56;

    localparam logic [2:0] CMD_LAST_K  = 3'd5;
    localparam logic [2:0] DATA_LAST_K = 3'd7;

    // command sequence slots
    localparam logic [2:0] SLOT_COL_CMD   = 3'd0;
    localparam logic [2:0] SLOT_COL_START = 3'd1;
    localparam logic [2:0] SLOT_COL_END   = 3'd2;
    localparam logic [2:0] SLOT_PAGE_CMD  = 3'd3;
    localparam logic [2:0] SLOT_PAGE_STRT = 3'd4;
    localparam logic [2:0] SLOT_PAGE_END  = 3'd5;

    typedef struct packed {
        logic       cmd;       // frame start, range commands go out
        logic       data;      // eighth row of a band, eight data bytes go out
        logic       frame_end; // last byte of the frame
        logic [7:0] col_end;
        logic [7:0] page_end;
    } item_t;

endpackage

// ----- rtl/core/rtp_ctrl.sv -----
// configuration registers and frame position tracking
`timescale 1ns / 1ps

module rtp_ctrl #(
    parameter int MAX_ROW_BYTES = rtp_pkg::DEF_MAX_ROW_BYTES,
    parameter int MAX_PAGES     = rtp_pkg::DEF_MAX_PAGES,
    localparam int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [rtp_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [rtp_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                               accept,
    output rtp_pkg::item_t                     item,
    output logic [CW-1:0]                      col,
    output logic [2:0]                         sub
);
    import rtp_pkg::*;

    localparam int RBW = $clog2(MAX_ROW_BYTES + 1);
    localparam int PW  = $clog2(MAX_PAGES + 1);
    localparam int RW  = $clog2(MAX_PAGES * 8);
    localparam int TW  = PW + 3;

    logic [ROW_BYTES_W-1:0]  row_bytes_reg;
    logic [PAGE_COUNT_W-1:0] page_count_reg;
    logic [RW-1:0]           row_reg, row_next;
    logic [CW-1:0]           col_reg, col_next;

    logic [RBW-1:0] eff_rb;
    logic [PW-1:0]  eff_pc;
    logic [TW-1:0]  rows;
    logic [RW-1:0]  row;
    logic [RBW-1:0] col_inc;
    logic [TW-1:0]  row_inc;
    logic [RBW+2:0] width_px;
    logic           restart;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_bytes_reg  <= ROW_BYTES_RST;
            page_count_reg <= PAGE_COUNT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_ROW_BYTES:  row_bytes_reg  <= cfg_wr_data[ROW_BYTES_W-1:0];
                REG_PAGE_COUNT: page_count_reg <= cfg_wr_data[PAGE_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // out of range settings saturate, zero acts as one
    always_comb begin
        if (row_bytes_reg == '0)
            eff_rb = RBW'(1);
        else if (int'(row_bytes_reg) > MAX_ROW_BYTES)
            eff_rb = RBW'(MAX_ROW_BYTES);
        else
            eff_rb = RBW'(row_bytes_reg);

        if (page_count_reg == '0)
            eff_pc = PW'(1);
        else if (int'(page_count_reg) > MAX_PAGES)
            eff_pc = PW'(MAX_PAGES);
        else
            eff_pc = PW'(page_count_reg);
    end

    assign rows    = {eff_pc, 3'b000};
    // a position left beyond a shrunk geometry restarts the frame
    assign restart = (TW'(row_reg) >= rows) || (RBW'(col_reg) >= eff_rb);
    assign row     = restart ? '0 : row_reg;
    assign col     = restart ? '0 : col_reg;
    assign sub     = row[2:0];

    assign col_inc  = RBW'(col) + RBW'(1);
    assign row_inc  = TW'(row) + TW'(1);
    assign width_px = {eff_rb, 3'b000} - (RBW + 3)'(1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_inc >= eff_rb) begin
                col_next = '0;
                row_next = (row_inc >= rows) ? '0 : RW'(row_inc);
            end else begin
                col_next = CW'(col_inc);
                row_next = row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    always_comb begin
        item.cmd       = (row == '0) && (col == '0);
        item.data      = (sub == 3'd7);
        item.frame_end = (TW'(row) == rows - TW'(1)) && (RBW'(col) == eff_rb - RBW'(1));
        item.col_end   = 8'(width_px);
        item.page_end  = 8'(eff_pc - PW'(1));
    end

endmodule

// ----- rtl/core/rtp_band.sv -----
// band store: first seven rows of the current band, one entry per column byte
`timescale 1ns / 1ps

module rtp_band #(
    parameter int MAX_ROW_BYTES = rtp_pkg::DEF_MAX_ROW_BYTES,
    localparam int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [CW-1:0]               wr_addr,
    input  logic [2:0]                  wr_lane,
    input  logic [7:0]                  wr_byte,
    input  logic                        rd_en,
    input  logic [CW-1:0]               rd_addr,
    output logic [rtp_pkg::BAND_W-1:0]  rd_data
);
    import rtp_pkg::*;

    logic [BAND_W-1:0] mem [MAX_ROW_BYTES];
    logic [BAND_W-1:0] rd_data_reg;

    // byte lane write, one row of the band at a time
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr][wr_lane*8 +: 8] <= wr_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/rtp_emit.sv -----
// result sequencer: holds one request and drives its results through the output register
`timescale 1ns / 1ps

module rtp_emit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  rtp_pkg::item_t              item,
    input  logic [7:0]                  px,
    input  logic [rtp_pkg::BAND_W-1:0]  entry,
    output logic                        ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_out_byte,
    output logic                        m_is_data,
    output logic                        m_run_last,
    output logic                        m_frame_last
);
    import rtp_pkg::*;

    logic       busy_reg, busy_next;
    item_t      item_reg;
    logic [7:0] px_reg;
    logic [2:0] k_reg, k_next;

    logic       m_valid_reg;
    logic [7:0] out_byte_reg;
    logic       is_data_reg;
    logic       run_last_reg;
    logic       frame_last_reg;

    logic       out_load;
    logic       at_end;
    logic [7:0] cmd_byte;
    logic [7:0] data_byte;
    logic [7:0] res_byte;

    assign out_load = !m_valid_reg || m_ready;
    assign at_end   = item_reg.cmd ? (k_reg == CMD_LAST_K) : (k_reg == DATA_LAST_K);
    // next request may enter as the last result of this one moves out
    assign ready    = !busy_reg || (out_load && at_end);

    always_comb begin
        busy_next = busy_reg;
        k_next    = k_reg;
        if (load) begin
            busy_next = item.cmd || item.data;
            k_next    = '0;
        end else if (busy_reg && out_load) begin
            if (at_end)
                busy_next = 1'b0;
            else
                k_next = k_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item;
            px_reg   <= px;
        end
    end

    always_comb begin
        case (k_reg)
            SLOT_COL_CMD:   cmd_byte = CMD_COL_RANGE;
            SLOT_COL_START: cmd_byte = 8'h00;
            SLOT_COL_END:   cmd_byte = item_reg.col_end;
            SLOT_PAGE_CMD:  cmd_byte = CMD_PAGE_RANGE;
            SLOT_PAGE_STRT: cmd_byte = 8'h00;
            SLOT_PAGE_END:  cmd_byte = item_reg.page_end;
            default:        cmd_byte = 8'h00;
        endcase
    end

    // transpose one pixel column: bit r from stored row r, bit 7 from the live row
    always_comb begin
        for (int r = 0; r < 7; r++) begin
            data_byte[r] = entry[r*8 + int'(k_reg)];
        end
        data_byte[7] = px_reg[k_reg];
    end

    assign res_byte = item_reg.cmd ? cmd_byte : data_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_byte_reg   <= res_byte;
            is_data_reg    <= !item_reg.cmd;
            run_last_reg   <= at_end;
            frame_last_reg <= !item_reg.cmd && at_end && item_reg.frame_end;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_is_data    = is_data_reg;
    assign m_run_last   = run_last_reg;
    assign m_frame_last = frame_last_reg;

endmodule

// ----- rtl/core/row_to_page_pixel_transposer_core.sv -----
// top level of the row to page pixel transposer
//
//   channel   direction  signals
//   s_        in         s_valid, s_ready, s_pixel_byte
//   m_        out        m_valid, m_ready, m_out_byte, m_is_data, m_run_last, m_frame_last
//   cfg_      in         cfg_wr_en, cfg_wr_index, cfg_wr_data
//
// a store-only request produces no result; a frame start request six results and an
// eighth-row request eight, one result per cycle out of the output register barring an m_ready stall.
// the next request is taken as its predecessor's last result enters the output register.
// the band store is read at the accepting edge into a registered read port.
// reset zeroes the position and restores the default geometry; the band store holds
// no reset value.
// a stall on m_ready holds the output register and the pending request.
`timescale 1ns / 1ps

module row_to_page_pixel_transposer_core #(
    parameter int MAX_ROW_BYTES = rtp_pkg::DEF_MAX_ROW_BYTES,
    parameter int MAX_PAGES     = rtp_pkg::DEF_MAX_PAGES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [rtp_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [rtp_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_pixel_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_out_byte,
    output logic                            m_is_data,
    output logic                            m_run_last,
    output logic                            m_frame_last
);
    import rtp_pkg::*;

    localparam int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

    logic              accept;
    item_t             item;
    logic [CW-1:0]     col;
    logic [2:0]        sub;
    logic [BAND_W-1:0] entry;

    assign accept = s_valid && s_ready;

    rtp_ctrl #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_PAGES     (MAX_PAGES)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .accept       (accept),
        .item         (item),
        .col          (col),
        .sub          (sub)
    );

    rtp_band #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_band (
        .aclk    (aclk),
        .wr_en   (accept && !item.data),
        .wr_addr (col),
        .wr_lane (sub),
        .wr_byte (s_pixel_byte),
        .rd_en   (accept && item.data),
        .rd_addr (col),
        .rd_data (entry)
    );

    rtp_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (accept),
        .item         (item),
        .px           (s_pixel_byte),
        .entry        (entry),
        .ready        (s_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_is_data    (m_is_data),
        .m_run_last   (m_run_last),
        .m_frame_last (m_frame_last)
    );

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the row to page pixel transposer core
`timescale 1ns / 1ps

module testbench;
    import rtp_pkg::*;

    localparam int MAX_RB          = DEF_MAX_ROW_BYTES;
    localparam int MAX_PG          = DEF_MAX_PAGES;
    localparam int STALL_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_ITEMS    = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER  = 70;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       run_last;
        logic       frame_last;
    } page_result_t;

    typedef enum logic {ROW_CFG, ROW_PIXEL} row_kind_e;
    typedef enum logic [1:0] {EXP_PREDICTED, EXP_NONE, EXP_FRAME_START, EXP_FILL} exp_kind_e;

    typedef struct {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [7:0]            px;
        exp_kind_e             want;
        logic [7:0]            col_end;
        logic [7:0]            page_end;
        logic [7:0]            fill;
        logic                  frame_end;
    } stim_row_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_pixel_byte = 8'h00;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [7:0]            m_out_byte;
    logic                  m_is_data;
    logic                  m_run_last;
    logic                  m_frame_last;

    // predictor state
    logic [BAND_W-1:0]       band_rows [MAX_RB];
    int unsigned             pos_row;
    int unsigned             pos_col;
    logic [ROW_BYTES_W-1:0]  rb_setting;
    logic [PAGE_COUNT_W-1:0] pc_setting;

    page_result_t predicted_run [$];
    page_result_t page_expect [$];
    stim_row_t    stim_table [$];
    stim_row_t    stim_cur;
    page_result_t mon_got;
    page_result_t mon_want;

    int mismatches      = 0;
    int results_checked = 0;
    int idle_cycles     = 0;
    int send_burst      = 0;
    int recv_burst      = 0;
    int recv_stall      = 0;
    int recv_pick;
    bit held_off        = 1'b0;
    int random_sent     = 0;
    int phase_len;
    logic [CFG_DATA_W-1:0] phase_rb;
    logic [CFG_DATA_W-1:0] phase_pc;

    row_to_page_pixel_transposer_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_byte (s_pixel_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_is_data    (m_is_data),
        .m_run_last   (m_run_last),
        .m_frame_last (m_frame_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int unsigned clamp_width(input logic [ROW_BYTES_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_RB) return MAX_RB;
        return v;
    endfunction

    function automatic int unsigned clamp_pages(input logic [PAGE_COUNT_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_PG) return MAX_PG;
        return v;
    endfunction

    // works out the results of one accepted pixel byte and advances the position
    function automatic void transpose_pixel_byte(input logic [7:0] px);
        int unsigned       rb;
        int unsigned       pg;
        int unsigned       rows;
        int unsigned       sub;
        logic [BAND_W-1:0] entry;
        logic [7:0]        v;
        bit                last_byte;
        rb   = clamp_width(rb_setting);
        pg   = clamp_pages(pc_setting);
        rows = pg * 8;
        predicted_run.delete();
        // geometry shrank under the current position: start a new frame
        if (pos_row >= rows || pos_col >= rb) begin
            pos_row = 0;
            pos_col = 0;
        end
        sub = pos_row % 8;
        if (pos_row == 0 && pos_col == 0) begin
            predicted_run.push_back('{CMD_COL_RANGE, 1'b0, 1'b0, 1'b0});
            predicted_run.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
            predicted_run.push_back('{8'(rb * 8 - 1), 1'b0, 1'b0, 1'b0});
            predicted_run.push_back('{CMD_PAGE_RANGE, 1'b0, 1'b0, 1'b0});
            predicted_run.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
            predicted_run.push_back('{8'(pg - 1), 1'b0, sub != 7, 1'b0});
        end
        entry = band_rows[pos_col];
        if (sub != 7) begin
            band_rows[pos_col][sub*8 +: 8] = px;
        end else begin
            last_byte = (pos_row == rows - 1) && (pos_col == rb - 1);
            for (int b = 0; b < 8; b++) begin
                for (int r = 0; r < 7; r++) v[r] = entry[r*8 + b];
                v[7] = px[b];
                predicted_run.push_back('{v, 1'b1, b == 7, (b == 7) && last_byte});
            end
        end
        pos_col++;
        if (pos_col >= rb) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= rows) pos_row = 0;
        end
    endfunction

    // bytes left in the current band, zero at a band start
    function automatic int unsigned bytes_to_band_end();
        int unsigned rb;
        int unsigned rows;
        rb   = clamp_width(rb_setting);
        rows = clamp_pages(pc_setting) * 8;
        if (pos_row >= rows || pos_col >= rb) return 0;
        if (pos_row % 8 == 0 && pos_col == 0) return 0;
        return (rb - pos_col) + (7 - pos_row % 8) * rb;
    endfunction

    function automatic int pick_gap();
        int r;
        if (send_burst > 0) begin
            send_burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            send_burst = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r = '{ROW_CFG, idx, val, 8'h00, EXP_NONE, 8'h00, 8'h00, 8'h00, 1'b0};
        stim_table.push_back(r);
    endfunction

    function automatic void add_px(input logic [7:0] px, input exp_kind_e want,
                                   input logic [7:0] col_end, input logic [7:0] page_end,
                                   input logic [7:0] fill, input logic frame_end);
        stim_row_t r;
        r = '{ROW_PIXEL, '0, '0, px, want, col_end, page_end, fill, frame_end};
        stim_table.push_back(r);
    endfunction

    task automatic push_pixel(input logic [7:0] px, input int gap);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_pixel_byte <= px;
        do @(posedge aclk); while (s_ready !== 1'b1);
        transpose_pixel_byte(px);
    endtask

    task automatic offer_random_pixel();
        int          r;
        logic [7:0]  px;
        r = $urandom_range(0, 9);
        if (r == 0) px = 8'h00;
        else if (r == 1) px = 8'hFF;
        else px = 8'($urandom_range(0, 255));
        push_pixel(px, pick_gap());
        foreach (predicted_run[k]) page_expect.push_back(predicted_run[k]);
    endtask

    // wait until every expected result is out and the block has gone quiet
    task automatic settle_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (page_expect.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        if (idx == REG_ROW_BYTES) rb_setting = val[ROW_BYTES_W-1:0];
        else if (idx == REG_PAGE_COUNT) pc_setting = val[PAGE_COUNT_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] rb_new,
                             input logic [CFG_DATA_W-1:0] pc_new, input int count);
        int unsigned pad;
        pad = 0;
        // widening mid-band would read columns never stored in this band
        if (clamp_width(rb_new[ROW_BYTES_W-1:0]) > clamp_width(rb_setting))
            pad = bytes_to_band_end();
        repeat (pad) offer_random_pixel();
        settle_block();
        write_reg(REG_ROW_BYTES, rb_new);
        write_reg(REG_PAGE_COUNT, pc_new);
        repeat (count) offer_random_pixel();
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            mon_got = '{m_out_byte, m_is_data, m_run_last, m_frame_last};
            results_checked++;
            if (page_expect.size() == 0) begin
                $display("%0t: unexpected result out_byte=%02h is_data=%b run_last=%b frame_last=%b",
                         $time, mon_got.out_byte, mon_got.is_data, mon_got.run_last,
                         mon_got.frame_last);
                mismatches++;
            end else begin
                mon_want = page_expect.pop_front();
                if (mon_got.out_byte !== mon_want.out_byte) begin
                    $display("%0t: out_byte expected %02h got %02h",
                             $time, mon_want.out_byte, mon_got.out_byte);
                    mismatches++;
                end
                if (mon_got.is_data !== mon_want.is_data) begin
                    $display("%0t: is_data expected %b got %b",
                             $time, mon_want.is_data, mon_got.is_data);
                    mismatches++;
                end
                if (mon_got.run_last !== mon_want.run_last) begin
                    $display("%0t: run_last expected %b got %b",
                             $time, mon_want.run_last, mon_got.run_last);
                    mismatches++;
                end
                if (mon_got.frame_last !== mon_want.frame_last) begin
                    $display("%0t: frame_last expected %b got %b",
                             $time, mon_want.frame_last, mon_got.frame_last);
                    mismatches++;
                end
            end
        end
    end

    // result side back-pressure, with one long hold-off to fill the block
    initial begin
        while (aresetn !== 1'b1) @(negedge aclk);
        forever begin
            @(negedge aclk);
            if (!held_off && results_checked >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end else if (recv_burst > 0) begin
                m_ready <= 1'b1;
                recv_burst--;
            end else if (recv_stall > 0) begin
                m_ready <= 1'b0;
                recv_stall--;
            end else begin
                recv_pick = $urandom_range(0, 99);
                if (recv_pick < 10) begin
                    recv_burst = $urandom_range(10, 40);
                    m_ready <= 1'b1;
                end else if (recv_pick < 18) begin
                    recv_stall = $urandom_range(10, 40);
                    m_ready <= 1'b0;
                end else if (recv_pick < 45) begin
                    recv_stall = $urandom_range(0, 2);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin
        rb_setting = ROW_BYTES_RST;
        pc_setting = PAGE_COUNT_RST;
        pos_row    = 0;
        pos_col    = 0;
        foreach (band_rows[i]) band_rows[i] = '0;

        // one column, with 0 pages acting as one: a frame is a single band
        add_cfg(REG_ROW_BYTES, 5'd1);
        add_cfg(REG_PAGE_COUNT, 5'd0);
        add_px(8'hFF, EXP_FRAME_START, 8'd7, 8'd0, 8'h00, 1'b0);
        for (int r = 1; r < 7; r++) add_px(8'hFF, EXP_NONE, 8'h00, 8'h00, 8'h00, 1'b0);
        add_px(8'hFF, EXP_FILL, 8'h00, 8'h00, 8'hFF, 1'b1);
        add_px(8'h00, EXP_FRAME_START, 8'd7, 8'd0, 8'h00, 1'b0);
        for (int r = 1; r < 7; r++) add_px(8'h00, EXP_NONE, 8'h00, 8'h00, 8'h00, 1'b0);
        add_px(8'h00, EXP_FILL, 8'h00, 8'h00, 8'h00, 1'b1);
        // walking one down the rows
        for (int r = 0; r < 8; r++)
            add_px(8'(1 << r), EXP_PREDICTED, 8'h00, 8'h00, 8'h00, 1'b0);
        // both registers past their top, saturating
        add_cfg(REG_ROW_BYTES, 5'd31);
        add_cfg(REG_PAGE_COUNT, 5'd31);
        add_px(8'hA5, EXP_FRAME_START, 8'd127, 8'd7, 8'h00, 1'b0);
        // zero width acts as one, column 1 now lies outside so the frame restarts
        add_cfg(REG_ROW_BYTES, 5'd0);
        add_px(8'h5A, EXP_FRAME_START, 8'd7, 8'd7, 8'h00, 1'b0);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (stim_table[i]) begin
            stim_cur = stim_table[i];
            if (stim_cur.kind == ROW_CFG) begin
                settle_block();
                write_reg(stim_cur.reg_idx, stim_cur.reg_val);
            end else begin
                push_pixel(stim_cur.px, pick_gap());
                case (stim_cur.want)
                    EXP_PREDICTED: begin
                        foreach (predicted_run[k]) page_expect.push_back(predicted_run[k]);
                    end
                    EXP_FRAME_START: begin
                        page_expect.push_back('{CMD_COL_RANGE, 1'b0, 1'b0, 1'b0});
                        page_expect.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
                        page_expect.push_back('{stim_cur.col_end, 1'b0, 1'b0, 1'b0});
                        page_expect.push_back('{CMD_PAGE_RANGE, 1'b0, 1'b0, 1'b0});
                        page_expect.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
                        page_expect.push_back('{stim_cur.page_end, 1'b0, 1'b1, 1'b0});
                    end
                    EXP_FILL: begin
                        for (int k = 0; k < 8; k++)
                            page_expect.push_back('{stim_cur.fill, 1'b1, k == 7,
                                                    (k == 7) && stim_cur.frame_end});
                    end
                    default: begin
                    end
                endcase
            end
        end

        // one band of four-byte rows ending the frame, the receiver hold-off lands
        // in its eighth row while requests keep coming
        run_phase(5'd4, 5'd2, 32);

        while (random_sent < RANDOM_ITEMS) begin
            recv_pick = $urandom_range(0, 99);
            if (recv_pick < 80) phase_rb = 5'($urandom_range(1, 4));
            else if (recv_pick < 90) phase_rb = 5'($urandom_range(5, 16));
            else phase_rb = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
            recv_pick = $urandom_range(0, 99);
            if (recv_pick < 70) phase_pc = 5'($urandom_range(2, 3));
            else if (recv_pick < 90) phase_pc = 5'($urandom_range(4, 8));
            else phase_pc = 5'($urandom_range(0, 31));
            phase_len = $urandom_range(4, 16);
            run_phase(phase_rb, phase_pc, phase_len);
            random_sent += phase_len;
        end

        settle_block();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
